/* rtl/sysres_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sysres_pkg
// Types and constants shared by the systematic resampler modules.
// ----------------------------------------------------------------------------
package sysres_pkg;

	localparam int CMD_BITS = 1;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_WRITE    = 1'b0,
		CMD_RESAMPLE = 1'b1
	} cmd_t;

	localparam logic REG_WEIGHTS = 1'b0;
	localparam logic REG_SAMPLES = 1'b1;

	typedef struct packed {
		logic        command;
		logic [7:0]  weight_slot;
		logic [31:0] weight_value;
		logic [15:0] seed_fraction;
		logic [39:0] denominator;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] sample_index;
		logic [5:0] sample_number;
		logic       last;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_SETUP,
		ST_READ,
		ST_MUL,
		ST_CMP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic sum_step;
		logic setup;
		logic mul;
		logic advance_j;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic sum_done;
		logic ge;
		logic j_at_end;
		logic k_last;
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

/* rtl/sysres_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sysres_ctrl
// Sequencer for the summing pass and the sample walk.
// ----------------------------------------------------------------------------
module sysres_ctrl
	import sysres_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  dp_status_t      status,
	output logic            busy,
	output dp_cmd_t         cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (status.sum_done) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d = ST_MUL;
			end
			ST_READ: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (!status.ge && !status.j_at_end) begin
					cmd.advance_j = 1'b1;
					state_d = ST_READ;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_d = status.k_last ? ST_IDLE : ST_MUL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/sysres_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sysres_dp
// Weight and cumulative memories, products, compare and output register.
// ----------------------------------------------------------------------------
module sysres_dp
	import sysres_pkg::*;
#(
	parameter int MAX_WEIGHTS = 256,
	parameter int MAX_SAMPLES = 64,
	parameter int WEIGHT_BITS = 32,
	parameter int SEED_BITS   = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  in_beat_t        in_beat,
	input  wire logic       wr_en,
	input  wire logic [8:0] w_use,
	input  wire logic [6:0] s_use,
	input  dp_cmd_t         cmd,
	output dp_status_t      status,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_beat_t       out_beat
);

	localparam int IW = $clog2(MAX_WEIGHTS);
	localparam int KW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = WEIGHT_BITS + IW;
	localparam int TW = SEED_BITS + KW;
	localparam int SW = 7 + SEED_BITS;
	localparam int PW = CW + SW;

	logic [WEIGHT_BITS-1:0] wmem [MAX_WEIGHTS];
	logic [CW-1:0]          cmem [MAX_WEIGHTS];
	logic [WEIGHT_BITS-1:0] wrd_q;
	logic [CW-1:0]          crd_q, acc_q;
	logic [IW:0]            ri_q, wi_q;
	logic                   rvalid_q;
	logic [IW-1:0]          j_q;
	logic [KW-1:0]          k_q;
	logic [SEED_BITS-1:0]   seed_q;
	logic [39:0]            den_q;
	logic [PW-1:0]          lhs_q;
	logic [TW+40-1:0]       rhs_q;
	logic [IW:0]            wlast;

	assign wlast = (IW+1)'(w_use - 9'd1);

	always_ff @(posedge clk) begin
		if (wr_en && (in_beat.weight_slot < MAX_WEIGHTS)) begin
			wmem[IW'(in_beat.weight_slot)] <= in_beat.weight_value[WEIGHT_BITS-1:0];
		end
		wrd_q <= wmem[ri_q[IW-1:0]];
		if (rvalid_q) begin
			cmem[wi_q[IW-1:0]] <= acc_q + CW'(wrd_q);
		end
		crd_q <= cmem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ri_q <= '0;
			wi_q <= '0;
			rvalid_q <= 1'b0;
			j_q <= '0;
			k_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				ri_q <= '0;
				wi_q <= '0;
				rvalid_q <= 1'b0;
				j_q <= '0;
				k_q <= '0;
			end else if (cmd.sum_step) begin
				rvalid_q <= (ri_q <= wlast);
				if (ri_q <= wlast) ri_q <= ri_q + 1'b1;
				if (rvalid_q) wi_q <= wi_q + 1'b1;
			end
			if (cmd.advance_j) j_q <= j_q + 1'b1;
			if (cmd.emit) k_q <= k_q + 1'b1;
			if (cmd.emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
			seed_q <= in_beat.seed_fraction[SEED_BITS-1:0];
			den_q <= in_beat.denominator;
		end else if (rvalid_q) begin
			acc_q <= acc_q + CW'(wrd_q);
		end
		if (cmd.setup && den_q == '0) den_q <= 40'(acc_q);
		if (cmd.mul) begin
			lhs_q <= PW'(crd_q) * PW'({s_use, {SEED_BITS{1'b0}}});
			rhs_q <= (TW+40)'({k_q, seed_q}) * (TW+40)'(den_q);
		end
		if (cmd.emit) begin
			out_beat.sample_index <= 8'(j_q);
			out_beat.sample_number <= 6'(k_q);
			out_beat.last <= ((7'(k_q) + 7'd1) == s_use);
		end
	end

	always_comb begin
		status.sum_done = (wi_q == w_use[IW:0]) && !rvalid_q;
		status.ge = ((PW > TW+40) ? PW : TW+40)'(lhs_q) >=
			((PW > TW+40) ? PW : TW+40)'(rhs_q);
		status.j_at_end = ({1'b0, j_q} == wlast);
		status.k_last = ((7'(k_q) + 7'd1) == s_use);
		status.out_busy = out_valid && out_stall;
	end

endmodule
`default_nettype wire

/* rtl/systematic_resampler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// systematic_resampler
// Systematic resampling of stored particle weights by integer comparison.
// ----------------------------------------------------------------------------
// A weight write is accepted whenever no resample is in progress; writes are
// accepted back to back while idle. A resample runs a summing pass through the
// weight memory and the setup, then walk steps (memory read, product register,
// compare) and emitted samples (product register, compare, output register)
// plus any output stall. The asynchronous reset returns the sequencer to idle
// and the configuration registers to their maximum counts; memories are
// not cleared.
// ----------------------------------------------------------------------------
module systematic_resampler
	import sysres_pkg::*;
#(
	parameter int MAX_WEIGHTS = 256,
	parameter int MAX_SAMPLES = 64,
	parameter int WEIGHT_BITS = 32,
	parameter int SEED_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [8:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  in_beat_t         in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_beat_t        out_data
);

	logic [8:0] w_use_q;
	logic [6:0] s_use_q;
	logic       busy, acc;
	dp_cmd_t    cmd;
	dp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_use_q <= 9'(MAX_WEIGHTS);
			s_use_q <= 7'(MAX_SAMPLES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WEIGHTS: w_use_q <= (cfg_data == 9'd0) ? 9'd1 :
					(32'(cfg_data) > MAX_WEIGHTS) ? 9'(MAX_WEIGHTS) : cfg_data;
				REG_SAMPLES: s_use_q <= (cfg_data[6:0] == 7'd0) ? 7'd1 :
					(32'(cfg_data[6:0]) > MAX_SAMPLES) ? 7'(MAX_SAMPLES) : cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign in_stall = busy;
	assign acc = in_valid && !in_stall;

	sysres_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.start(acc && in_data.command == CMD_RESAMPLE),
		.status(status), .busy(busy), .cmd(cmd)
	);

	sysres_dp #(
		.MAX_WEIGHTS(MAX_WEIGHTS), .MAX_SAMPLES(MAX_SAMPLES),
		.WEIGHT_BITS(WEIGHT_BITS), .SEED_BITS(SEED_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_data),
		.wr_en(acc && in_data.command == CMD_WRITE),
		.w_use(w_use_q), .s_use(s_use_q), .cmd(cmd), .status(status),
		.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_data)
	);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid && out_stall))
		else $error("beat overwritten while stalled");
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy)
		else $error("resample started while busy");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance_j |-> !status.j_at_end)
		else $error("walk overran last weight");

endmodule
`default_nettype wire
